/* src/sync_len_frame_deframer_crc8_unit_defines.svh */
// Assertion macros shared by the deframer checker.
`ifndef SYNC_LEN_FRAME_DEFRAMER_CRC8_UNIT_DEFINES_SVH
`define SYNC_LEN_FRAME_DEFRAMER_CRC8_UNIT_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define SLDCRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sldcrc same-cycle check failed");

// Property that must hold in the cycle after its antecedent.
`define SLDCRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sldcrc next-cycle check failed");

`endif

/* src/sldcrc_pkg.sv */
// Package with types, constants and the CRC-8 function of the deframer.
package sldcrc_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int CNT_W       = 6;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h07;
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] MAX_LEN         = BYTE_W'(MAX_PAYLOAD + 1);

    typedef enum logic [1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_CRC_SYNC    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        VERD_GOOD = 2'd0,
        VERD_CRC  = 2'd1,
        VERD_LEN  = 2'd2
    } t_verdict;

    typedef enum logic [2:0] {
        FS_HUNT,
        FS_SYNC2,
        FS_LEN,
        FS_CMD,
        FS_PARAMS,
        FS_CRC
    } t_frame_st;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_READ,
        EM_LOAD
    } t_emit_st;

    // Verdict or header raised by the parser for the emitter.
    typedef struct packed {
        logic              valid;
        t_verdict          verdict;
        logic [BYTE_W-1:0] cmd;
        logic [CNT_W-1:0]  cnt;
    } t_result_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    // MSB-first CRC-8, no reflection, no final xor.
    function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

/* src/sldcrc_ifs.sv */
// Valid/ready channel interfaces for received bytes and result words.
interface sldcrc_byte_if import sldcrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sldcrc_res_if import sldcrc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              item_kind;
    logic [1:0]        verdict;
    logic [BYTE_W-1:0] command_id;
    logic [CNT_W-1:0]  param_count;
    logic [BYTE_W-1:0] param_byte;
    logic              last_of_run;

    modport source (output valid, output item_kind, output verdict, output command_id,
                    output param_count, output param_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input item_kind, input verdict, input command_id,
                  input param_count, input param_byte, input last_of_run,
                  output ready);
endinterface

/* src/sldcrc_ram.sv */
// Simple dual-port RAM with one write port and a registered read port.
module sldcrc_ram #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/sldcrc_parser.sv */
// Frame parser: sync hunt, length and command capture, running CRC and parameter stores.
module sldcrc_parser import sldcrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_data,
    input  logic              i_acc,
    input  logic [BYTE_W-1:0] i_byte,
    output t_mem_wr           o_wr,
    output t_result_req       o_req
);
    logic [BYTE_W-1:0] r_sync_first;
    logic [BYTE_W-1:0] r_sync_second;
    logic              r_crc_sync;

    t_frame_st         r_state, n_state;
    logic [BYTE_W-1:0] r_crc, n_crc;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_widx, n_widx;

    logic [BYTE_W-1:0] crc_step;
    logic [BYTE_W-1:0] crc_first;
    logic [CNT_W-1:0]  rem_dec;

    assign crc_step  = crc8_update(r_crc, i_byte);
    assign crc_first = crc8_update('0, i_byte);
    assign rem_dec   = (r_rem != '0) ? r_rem - CNT_W'(1) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
            r_crc_sync    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg_data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg_data;
                CFG_CRC_SYNC:    r_crc_sync    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_HUNT;
            r_crc   <= '0;
            r_cmd   <= '0;
            r_rem   <= '0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_crc   <= n_crc;
            r_cmd   <= n_cmd;
            r_rem   <= n_rem;
            r_widx  <= n_widx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_crc   = r_crc;
        n_cmd   = r_cmd;
        n_rem   = r_rem;
        n_widx  = r_widx;
        o_wr    = '{en: 1'b0, addr: r_widx[ADDR_W-1:0], data: i_byte};
        o_req   = '{valid: 1'b0, verdict: VERD_GOOD, cmd: r_cmd, cnt: '0};
        if (i_acc) begin
            case (r_state)
                FS_HUNT: begin
                    if (i_byte == r_sync_first) begin
                        n_crc   = r_crc_sync ? crc_first : '0;
                        n_widx  = '0;
                        n_state = FS_SYNC2;
                    end
                end
                FS_SYNC2: begin
                    // The second sync wins when both sync bytes are alike.
                    if (i_byte == r_sync_second) begin
                        if (r_crc_sync) begin
                            n_crc = crc_step;
                        end
                        n_state = FS_LEN;
                    end else if (i_byte == r_sync_first) begin
                        n_crc   = r_crc_sync ? crc_first : '0;
                        n_widx  = '0;
                        n_state = FS_SYNC2;
                    end else begin
                        n_state = FS_HUNT;
                    end
                end
                FS_LEN: begin
                    if (i_byte == '0 || i_byte > MAX_LEN) begin
                        o_req   = '{valid: 1'b1, verdict: VERD_LEN, cmd: '0, cnt: '0};
                        n_state = FS_HUNT;
                    end else begin
                        n_crc   = crc_step;
                        n_rem   = CNT_W'(i_byte - BYTE_W'(1));
                        n_state = FS_CMD;
                    end
                end
                FS_CMD: begin
                    n_cmd   = i_byte;
                    n_crc   = crc_step;
                    n_widx  = '0;
                    n_state = (r_rem == '0) ? FS_CRC : FS_PARAMS;
                end
                FS_PARAMS: begin
                    n_crc = crc_step;
                    if (r_widx < CNT_W'(MAX_PAYLOAD)) begin
                        o_wr.en = 1'b1;
                        n_widx  = r_widx + CNT_W'(1);
                    end
                    n_rem = rem_dec;
                    if (rem_dec == '0) begin
                        n_state = FS_CRC;
                    end
                end
                FS_CRC: begin
                    if (i_byte == r_crc) begin
                        o_req = '{valid: 1'b1, verdict: VERD_GOOD, cmd: r_cmd, cnt: r_widx};
                    end else begin
                        o_req = '{valid: 1'b1, verdict: VERD_CRC, cmd: r_cmd, cnt: '0};
                    end
                    n_state = FS_HUNT;
                end
                default: begin
                    n_state = FS_HUNT;
                end
            endcase
        end
    end
endmodule

/* src/sldcrc_emit.sv */
// Result emitter: output register, header load and parameter read-out from the RAM.
module sldcrc_emit import sldcrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_result_req       i_req,
    output t_mem_rd           o_rd,
    input  logic [BYTE_W-1:0] i_rd_data,
    output logic              o_take_ok,
    sldcrc_res_if.source      o_res
);
    t_emit_st          r_st, n_st;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    logic              r_kind, n_kind;
    logic [1:0]        r_verd, n_verd;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_pcnt, n_pcnt;
    logic [BYTE_W-1:0] r_pbyte, n_pbyte;
    logic              r_last, n_last;

    logic              load_ok;
    logic [CNT_W-1:0]  idx_inc;

    assign load_ok   = !r_out_valid || o_res.ready;
    assign o_take_ok = (r_st == EM_IDLE) && load_ok;
    assign idx_inc   = r_idx + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= EM_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_verd  <= n_verd;
        r_cmd   <= n_cmd;
        r_pcnt  <= n_pcnt;
        r_pbyte <= n_pbyte;
        r_last  <= n_last;
    end

    always_comb begin
        n_st        = r_st;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_verd      = r_verd;
        n_cmd       = r_cmd;
        n_pcnt      = r_pcnt;
        n_pbyte     = r_pbyte;
        n_last      = r_last;
        o_rd        = '{en: 1'b0, addr: r_idx[ADDR_W-1:0]};
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_st)
            EM_IDLE: begin
                // A request only arrives with a byte that was taken while the register was free.
                if (i_req.valid) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b0;
                    n_verd      = i_req.verdict;
                    n_cmd       = i_req.cmd;
                    n_pcnt      = i_req.cnt;
                    n_pbyte     = '0;
                    n_last      = (i_req.cnt == '0);
                    n_cnt       = i_req.cnt;
                    n_idx       = '0;
                    if (i_req.cnt != '0) begin
                        n_st = EM_READ;
                    end
                end
            end
            EM_READ: begin
                o_rd.en = 1'b1;
                n_st    = EM_LOAD;
            end
            EM_LOAD: begin
                if (load_ok) begin
                    n_out_valid = 1'b1;
                    n_kind      = 1'b1;
                    n_verd      = VERD_GOOD;
                    n_cmd       = '0;
                    n_pcnt      = '0;
                    n_pbyte     = i_rd_data;
                    n_last      = (idx_inc == r_cnt);
                    n_idx       = idx_inc;
                    n_st        = (idx_inc == r_cnt) ? EM_IDLE : EM_READ;
                end
            end
            default: begin
                n_st = EM_IDLE;
            end
        endcase
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.item_kind   = r_kind;
    assign o_res.verdict     = r_verd;
    assign o_res.command_id  = r_cmd;
    assign o_res.param_count = r_pcnt;
    assign o_res.param_byte  = r_pbyte;
    assign o_res.last_of_run = r_last;
endmodule

/* src/sync_len_frame_deframer_crc8_unit.sv */
// Top level of the sync/length framed deframer with CRC-8 check.
//
//  channel   direction  payload                                              word
//  i_rx      in         rx_byte                                              one received byte
//  o_res     out        item_kind verdict command_id param_count param_byte  one result
//                       last_of_run
//  i_cfg_*   in         idx (sync_first, sync_second, crc_includes_sync)     register write
//
// A byte that yields no result or a single result leaves the emitter in its idle state.
// A good frame with N parameters sends the header and then, for each parameter word,
// a read of the parameter RAM, whose data is registered, then the load of the
// output register. i_rx.ready stays low while these words are sent and while a full
// output register is not being taken. Reset is synchronous and restores the register
// defaults; the parameter RAM needs no clearing.
module sync_len_frame_deframer_crc8_unit import sldcrc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [BYTE_W-1:0] i_cfg_data,
    sldcrc_byte_if.sink       i_rx,
    sldcrc_res_if.source      o_res
);
    t_mem_wr           mem_wr;
    t_mem_rd           mem_rd;
    t_result_req       req;
    logic [BYTE_W-1:0] rd_data;
    logic              take_ok;
    logic              in_acc;

    assign i_rx.ready = take_ok;
    assign in_acc     = i_rx.valid && take_ok;

    sldcrc_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (in_acc),
        .i_byte     (i_rx.rx_byte),
        .o_wr       (mem_wr),
        .o_req      (req)
    );

    sldcrc_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_wr.en),
        .i_waddr (mem_wr.addr),
        .i_wdata (mem_wr.data),
        .i_re    (mem_rd.en),
        .i_raddr (mem_rd.addr),
        .o_rdata (rd_data)
    );

    sldcrc_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req),
        .o_rd      (mem_rd),
        .i_rd_data (rd_data),
        .o_take_ok (take_ok),
        .o_res     (o_res)
    );
endmodule

/* src/sldcrc_checker.sv */
// Port-level checker for the deframer and its bind to the top level.
`include "sync_len_frame_deframer_crc8_unit_defines.svh"

module sldcrc_checker import sldcrc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_kind,
    input logic [1:0]        i_out_verdict,
    input logic [BYTE_W-1:0] i_out_cmd,
    input logic [CNT_W-1:0]  i_out_count,
    input logic [BYTE_W-1:0] i_out_param,
    input logic              i_out_last
);
    // A stalled result word keeps its contents.
    `SLDCRC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable({i_out_kind, i_out_verdict, i_out_cmd, i_out_count, i_out_param, i_out_last}))

    // A byte is never taken while a result word sits stalled.
    `SLDCRC_ASSERT_NOW(a_no_take_on_stall, i_in_valid && i_in_ready, !i_out_valid || i_out_ready)

    // Parameter words carry only the byte itself.
    `SLDCRC_ASSERT_NOW(a_param_clean, i_out_valid && i_out_kind, i_out_verdict == VERD_GOOD && i_out_cmd == '0 && i_out_count == '0)

    // A header or verdict ends the run exactly when no parameters follow it.
    `SLDCRC_ASSERT_NOW(a_head_last, i_out_valid && !i_out_kind, i_out_last == (i_out_count == '0))
endmodule

bind sync_len_frame_deframer_crc8_unit sldcrc_checker u_sldcrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_rx.valid),
    .i_in_ready    (i_rx.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_kind    (o_res.item_kind),
    .i_out_verdict (o_res.verdict),
    .i_out_cmd     (o_res.command_id),
    .i_out_count   (o_res.param_count),
    .i_out_param   (o_res.param_byte),
    .i_out_last    (o_res.last_of_run)
);
